[hw/rtl/assert_macros.svh]
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/mbrot_pkg.sv]
package mbrot_pkg;

  localparam int PIX_W       = 10;
  localparam int CNT_W       = 10;
  localparam int Q_W         = 32;
  localparam int STEP_W      = 31;
  localparam int PROD_W      = 2 * Q_W;
  localparam int FRAC_BITS   = 28;
  localparam int REG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int DEF_IMAGE_WIDTH  = 1024;
  localparam int DEF_IMAGE_HEIGHT = 1024;

  // 4.0 in q8.56
  localparam logic [PROD_W-1:0] ESCAPE_LIMIT = 64'h0400_0000_0000_0000;

  localparam logic [STEP_W-1:0]   RST_STEP     = 31'd524288;
  localparam logic [Q_W-1:0]      RST_OFFSET   = 32'd0;
  localparam logic [CNT_W-1:0]    RST_MAX_ITER = 10'd255;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STEP_REAL   = 3'd0,
    REG_STEP_IMAG   = 3'd1,
    REG_OFFSET_REAL = 3'd2,
    REG_OFFSET_IMAG = 3'd3,
    REG_MAX_ITER    = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [STEP_W-1:0]     step_real;
    logic [STEP_W-1:0]     step_imag;
    logic signed [Q_W-1:0] offset_real;
    logic signed [Q_W-1:0] offset_imag;
    logic [CNT_W-1:0]      max_iterations;
  } cfg_t;

  // clamp a wide signed value to the q4.28 range
  function automatic logic signed [Q_W-1:0] sat_q(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] hi;
    logic signed [PROD_W-1:0] lo;
    hi = PROD_W'($signed({1'b0, {(Q_W-1){1'b1}}}));
    lo = PROD_W'($signed({1'b1, {(Q_W-1){1'b0}}}));
    if (v > hi) begin
      sat_q = {1'b0, {(Q_W-1){1'b1}}};
    end else if (v < lo) begin
      sat_q = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      sat_q = v[Q_W-1:0];
    end
  endfunction

endpackage

[hw/rtl/mbrot_regs.sv]
module mbrot_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                wr_en,
  input  logic [mbrot_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0]    wr_data,
  output mbrot_pkg::cfg_t                     cfg
);
  import mbrot_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_real      <= RST_STEP;
      cfg.step_imag      <= RST_STEP;
      cfg.offset_real    <= RST_OFFSET;
      cfg.offset_imag    <= RST_OFFSET;
      cfg.max_iterations <= RST_MAX_ITER;
    end else if (wr_en) begin
      case (reg_idx_t'(wr_index))
        REG_STEP_REAL:   cfg.step_real      <= wr_data[STEP_W-1:0];
        REG_STEP_IMAG:   cfg.step_imag      <= wr_data[STEP_W-1:0];
        REG_OFFSET_REAL: cfg.offset_real    <= $signed(wr_data[Q_W-1:0]);
        REG_OFFSET_IMAG: cfg.offset_imag    <= $signed(wr_data[Q_W-1:0]);
        REG_MAX_ITER:    cfg.max_iterations <= wr_data[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

[hw/rtl/mbrot_mul.sv]
module mbrot_mul (
  input  logic                                    clk,
  input  logic signed [mbrot_pkg::Q_W-1:0]        a,
  input  logic signed [mbrot_pkg::Q_W-1:0]        b,
  output logic signed [mbrot_pkg::PROD_W-1:0]     p
);
  import mbrot_pkg::*;

  // one signed 32x32 product per cycle, registered
  always_ff @(posedge clk) begin
    p <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

[hw/rtl/mbrot_core.sv]
module mbrot_core #(
  parameter int IMAGE_WIDTH  = mbrot_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = mbrot_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  mbrot_pkg::cfg_t                    cfg,
  input  logic                               start,
  input  logic [mbrot_pkg::PIX_W-1:0]        column,
  input  logic [mbrot_pkg::PIX_W-1:0]        row,
  output logic                               busy,
  output logic                               done,
  output logic [mbrot_pkg::PIX_W-1:0]        out_column,
  output logic [mbrot_pkg::PIX_W-1:0]        out_row,
  output logic [mbrot_pkg::CNT_W-1:0]        iteration_count,
  output logic                               escaped
);
  import mbrot_pkg::*;

  localparam logic signed [Q_W-1:0] HALF_W = Q_W'(IMAGE_WIDTH / 2);
  localparam logic signed [Q_W-1:0] HALF_H = Q_W'(IMAGE_HEIGHT / 2);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MAPR = 9'b000000010,
    S_MAPI = 9'b000000100,
    S_CIM  = 9'b000001000,
    S_RR   = 9'b000010000,
    S_II   = 9'b000100000,
    S_RI   = 9'b001000000,
    S_UPD  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  logic [PIX_W-1:0]         col_q;
  logic [PIX_W-1:0]         row_q;
  logic signed [Q_W-1:0]    c_re;
  logic signed [Q_W-1:0]    c_im;
  logic signed [Q_W-1:0]    z_re;
  logic signed [Q_W-1:0]    z_im;
  logic signed [PROD_W-1:0] rr_q;
  logic signed [PROD_W-1:0] diff_q;
  logic [CNT_W-1:0]         count;

  logic signed [Q_W-1:0]    mul_a;
  logic signed [Q_W-1:0]    mul_b;
  logic signed [PROD_W-1:0] prod;

  logic signed [Q_W-1:0]    d_col;
  logic signed [Q_W-1:0]    d_row;
  logic [PROD_W-1:0]        mag2;
  logic                     stop;

  mbrot_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  assign d_col = $signed({{(Q_W-PIX_W){1'b0}}, col_q}) - HALF_W;
  assign d_row = $signed({{(Q_W-PIX_W){1'b0}}, row_q}) - HALF_H;

  // in S_RI the product register holds im^2
  assign mag2 = $unsigned(rr_q) + $unsigned(prod);
  assign stop = (mag2 > ESCAPE_LIMIT) || (count >= cfg.max_iterations);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_MAPR: begin
        mul_a = d_col;
        mul_b = $signed({1'b0, cfg.step_real});
      end
      S_MAPI: begin
        mul_a = d_row;
        mul_b = $signed({1'b0, cfg.step_imag});
      end
      S_RR: begin
        mul_a = z_re;
        mul_b = z_re;
      end
      S_II: begin
        mul_a = z_im;
        mul_b = z_im;
      end
      S_RI: begin
        mul_a = z_re;
        mul_b = z_im;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_MAPR;
      S_MAPR:  state_next = S_MAPI;
      S_MAPI:  state_next = S_CIM;
      S_CIM:   state_next = S_RR;
      S_RR:    state_next = S_II;
      S_II:    state_next = S_RI;
      S_RI:    state_next = stop ? S_DONE : S_UPD;
      S_UPD:   state_next = S_RR;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col_q <= column;
        row_q <= row;
      end
      S_MAPI: c_re <= sat_q(PROD_W'(sat_q(prod)) + PROD_W'(cfg.offset_real));
      S_CIM: begin
        c_im  <= sat_q(PROD_W'(sat_q(prod)) + PROD_W'(cfg.offset_imag));
        z_re  <= '0;
        z_im  <= '0;
        count <= '0;
      end
      S_II: rr_q <= prod;
      S_RI: begin
        diff_q          <= rr_q - prod;
        iteration_count <= count;
        escaped         <= count < cfg.max_iterations;
      end
      S_UPD: begin
        // arithmetic shifts give floor rounding; 2*re*im uses one bit less
        z_re  <= sat_q((diff_q >>> FRAC_BITS) + PROD_W'(c_re));
        z_im  <= sat_q((prod >>> (FRAC_BITS - 1)) + PROD_W'(c_im));
        count <= count + 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy       = (state != S_IDLE);
  assign done       = (state == S_DONE);
  assign out_column = col_q;
  assign out_row    = row_q;

endmodule

[hw/rtl/mandelbrot_escape_time_top.sv]
// channel   signals                                      handshake
// config    wr_en, wr_index, wr_data                     write when wr_en high
// request   start, column, row                           taken when start & !busy
// result    done, out_column, out_row,                   valid for the one cycle
//           iteration_count, escaped                     that done is high
//
// done follows acceptance after S_MAPR, S_MAPI and S_CIM, then S_RR, S_II and
// S_RI for each iteration run, with S_UPD between iterations; one shared
// 32x32 multiplier sets this. busy stays high from acceptance through the done
// cycle, so a new request is taken only once the last result is out
// rst is synchronous and restores the register defaults
// the receiver cannot stall: done is a single-cycle strobe
`include "assert_macros.svh"

module mandelbrot_escape_time_top #(
  parameter int IMAGE_WIDTH  = mbrot_pkg::DEF_IMAGE_WIDTH,
  parameter int IMAGE_HEIGHT = mbrot_pkg::DEF_IMAGE_HEIGHT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               wr_en,
  input  logic [mbrot_pkg::REG_IDX_W-1:0]    wr_index,
  input  logic [mbrot_pkg::CFG_DATA_W-1:0]   wr_data,
  input  logic                               start,
  input  logic [mbrot_pkg::PIX_W-1:0]        column,
  input  logic [mbrot_pkg::PIX_W-1:0]        row,
  output logic                               busy,
  output logic                               done,
  output logic [mbrot_pkg::PIX_W-1:0]        out_column,
  output logic [mbrot_pkg::PIX_W-1:0]        out_row,
  output logic [mbrot_pkg::CNT_W-1:0]        iteration_count,
  output logic                               escaped
);
  import mbrot_pkg::*;

  cfg_t cfg;

  mbrot_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  mbrot_core #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_core (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .start           (start),
    .column          (column),
    .row             (row),
    .busy            (busy),
    .done            (done),
    .out_column      (out_column),
    .out_row         (out_row),
    .iteration_count (iteration_count),
    .escaped         (escaped)
  );

  `ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "request accepted but core not busy")
  `ASSERT_NEXT(a_done_pulse, done, !done && !busy, "done strobe longer than one cycle")
  `ASSERT_IMPL(a_count_limit, done, iteration_count <= cfg.max_iterations, "count above limit")
  `ASSERT_IMPL(a_escaped_flag, done, escaped == (iteration_count < cfg.max_iterations), "escaped flag mismatch")

endmodule
